FILE: hdl/rk4_pkg.sv
// ----------------------------------------------------------------------------
// rk4_pkg
// Shared types, reset values and saturation helpers of the RK4 stepper.
// ----------------------------------------------------------------------------
package rk4_pkg;

   localparam int PT_W  = 40;
   localparam int ACC_W = 44;
   localparam int EXT_W = 46;

   typedef logic signed [PT_W-1:0]  pt_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic signed [EXT_W-1:0] ext_type;
   typedef logic [2:0][PT_W-1:0]    vec_type;
   typedef logic [2:0][ACC_W-1:0]   acc_vec_type;

   typedef enum logic [1:0] {
      CSR_COEF_A = 2'd0,
      CSR_COEF_B = 2'd1,
      CSR_COEF_C = 2'd2
   } csr_index_type;

   localparam logic signed [31:0] COEF_A_RESET = 32'sd53687091;
   localparam logic signed [31:0] COEF_B_RESET = 32'sd2684355;
   localparam logic signed [31:0] COEF_C_RESET = -32'sd107374182;

   localparam ext_type PT_MAX = ext_type'((46'sd1 <<< 39) - 46'sd1);
   localparam ext_type PT_MIN = ext_type'(-(46'sd1 <<< 39));

   function automatic ext_type ext46(input logic [PT_W-1:0] v);
      ext46 = {{(EXT_W-PT_W){v[PT_W-1]}}, v};
   endfunction

   function automatic acc_type ext44(input logic [PT_W-1:0] v);
      ext44 = {{(ACC_W-PT_W){v[PT_W-1]}}, v};
   endfunction

   function automatic pt_type sat40(input ext_type v);
      if (v > PT_MAX) begin
         sat40 = PT_MAX[PT_W-1:0];
      end else if (v < PT_MIN) begin
         sat40 = PT_MIN[PT_W-1:0];
      end else begin
         sat40 = v[PT_W-1:0];
      end
   endfunction

endpackage

FILE: hdl/rk4_delay.sv
// ----------------------------------------------------------------------------
// rk4_delay
// Enabled shift line that keeps side data aligned with the multipliers.
// ----------------------------------------------------------------------------
module rk4_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_i,
   output logic [WIDTH-1:0] q_o
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q_o = pipe_ff[DEPTH-1];

endmodule

FILE: hdl/rk4_fmul.sv
// ----------------------------------------------------------------------------
// rk4_fmul
// Three-stage signed fixed-point multiplier: magnitudes, four 22x22 partial
// products, then sum, round to nearest with ties away and saturate.
// ----------------------------------------------------------------------------
module rk4_fmul
   import rk4_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  logic             clock,
   input  logic             en,
   input  logic [ACC_W-1:0] a_i,
   input  logic [ACC_W-1:0] b_i,
   output logic [PT_W-1:0]  q_o,
   output logic [87:0]      prod_o
);

   localparam logic [87:0] RND    = 88'd1 << (FRAC_BITS - 1);
   localparam logic [87:0] LIM_NEG = 88'd1 << (PT_W - 1);
   localparam logic [87:0] LIM_POS = (88'd1 << (PT_W - 1)) - 88'd1;

   logic             neg1_ff, neg2_ff;
   logic [ACC_W-1:0] ma_ff, mb_ff;
   logic [43:0]      ll_ff, lh_ff, hl_ff, hh_ff;
   logic [87:0]      prod_in, prod_ff, rq, mq, lim;
   logic [PT_W-1:0]  q_in, q_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= a_i[ACC_W-1] ^ b_i[ACC_W-1];
         ma_ff   <= a_i[ACC_W-1] ? (ACC_W'(0) - a_i) : a_i;
         mb_ff   <= b_i[ACC_W-1] ? (ACC_W'(0) - b_i) : b_i;
         neg2_ff <= neg1_ff;
         ll_ff   <= 44'(ma_ff[21:0])  * 44'(mb_ff[21:0]);
         lh_ff   <= 44'(ma_ff[21:0])  * 44'(mb_ff[43:22]);
         hl_ff   <= 44'(ma_ff[43:22]) * 44'(mb_ff[21:0]);
         hh_ff   <= 44'(ma_ff[43:22]) * 44'(mb_ff[43:22]);
         q_ff    <= q_in;
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      prod_in = {44'd0, ll_ff} + ({44'd0, lh_ff} << 22) + ({44'd0, hl_ff} << 22)
              + {hh_ff, 44'd0};
      rq      = (prod_in + RND) >> FRAC_BITS;
      lim     = neg2_ff ? LIM_NEG : LIM_POS;
      mq      = (rq > lim) ? lim : rq;
      q_in    = neg2_ff ? (PT_W'(0) - mq[PT_W-1:0]) : mq[PT_W-1:0];
   end

   assign q_o    = q_ff;
   assign prod_o = prod_ff;

endmodule

FILE: hdl/rk4_kstage.sv
// ----------------------------------------------------------------------------
// rk4_kstage
// One Runge-Kutta stage: derivative at the stage point, the next stage point
// and the weighted running sum of slopes.
// ----------------------------------------------------------------------------
module rk4_kstage
   import rk4_pkg::*;
#(
   parameter int          FRAC_BITS  = 28,
   parameter logic [43:0] STEP       = 44'd0,
   parameter bit          WEIGHT_TWO = 1'b0
) (
   input  logic              clock,
   input  logic              en,
   input  logic [31:0]       coef_a_i,
   input  logic [31:0]       coef_b_i,
   input  logic [31:0]       coef_c_i,
   input  vec_type           p_i,
   input  vec_type           t_i,
   input  acc_vec_type       s_i,
   output vec_type           p_o,
   output vec_type           t_o,
   output acc_vec_type       s_o
);

   logic [ACC_W-1:0] ca, cb, cc, tx, ty, tz;
   logic [PT_W-1:0]  m_ax, m_yz, m_bx, m_cy, m_xz, m_xy, tz3;
   vec_type          k_in, k_ff, k3, mh, p7;
   acc_vec_type      s7;
   vec_type          p_ff, t_in, t_ff;
   acc_vec_type      s_in, s_ff;
   logic [87:0]      unused_prod [9];

   assign ca = {{12{coef_a_i[31]}}, coef_a_i};
   assign cb = {{12{coef_b_i[31]}}, coef_b_i};
   assign cc = {{12{coef_c_i[31]}}, coef_c_i};
   assign tx = ext44(t_i[0]);
   assign ty = ext44(t_i[1]);
   assign tz = ext44(t_i[2]);

   rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_ax (.clock, .en, .a_i(ca), .b_i(tx),
      .q_o(m_ax), .prod_o(unused_prod[0]));
   rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_yz (.clock, .en, .a_i(ty), .b_i(tz),
      .q_o(m_yz), .prod_o(unused_prod[1]));
   rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_bx (.clock, .en, .a_i(cb), .b_i(tx),
      .q_o(m_bx), .prod_o(unused_prod[2]));
   rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_cy (.clock, .en, .a_i(cc), .b_i(ty),
      .q_o(m_cy), .prod_o(unused_prod[3]));
   rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_xz (.clock, .en, .a_i(tx), .b_i(tz),
      .q_o(m_xz), .prod_o(unused_prod[4]));
   rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_xy (.clock, .en, .a_i(tx), .b_i(ty),
      .q_o(m_xy), .prod_o(unused_prod[5]));

   rk4_delay #(.WIDTH(PT_W), .DEPTH(3)) u_tz (.clock, .en, .d_i(t_i[2]), .q_o(tz3));
   rk4_delay #(.WIDTH(3*PT_W), .DEPTH(7)) u_p (.clock, .en, .d_i(p_i), .q_o(p7));
   rk4_delay #(.WIDTH(3*ACC_W), .DEPTH(7)) u_s (.clock, .en, .d_i(s_i), .q_o(s7));

   always_comb begin
      k_in[0] = sat40(ext46(m_ax) + ext46(m_yz));
      k_in[1] = sat40(ext46(sat40(ext46(m_bx) + ext46(m_cy))) - ext46(m_xz));
      k_in[2] = sat40(ext_type'(0) - ext46(tz3) - ext46(m_xy));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff <= k_in;
      end
   end

   rk4_delay #(.WIDTH(3*PT_W), .DEPTH(3)) u_k (.clock, .en, .d_i(k_ff), .q_o(k3));

   for (genvar i = 0; i < 3; i++) begin : g_step
      rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_h (.clock, .en, .a_i(ext44(k_ff[i])),
         .b_i(STEP), .q_o(mh[i]), .prod_o(unused_prod[6+i]));
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = sat40(ext46(p7[i]) + ext46(mh[i]));
         s_in[i] = $signed(s7[i]) + (WEIGHT_TWO ? (ext44(k3[i]) <<< 1) : ext44(k3[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p7;
         t_ff <= t_in;
         s_ff <= s_in;
      end
   end

   assign p_o = p_ff;
   assign t_o = t_ff;
   assign s_o = s_ff;

endmodule

FILE: hdl/rk4_update.sv
// ----------------------------------------------------------------------------
// rk4_update
// Final update x + s*h/6 with saturation, then the exact escape test on the
// sum of squares. Outputs are registered.
// ----------------------------------------------------------------------------
module rk4_update
   import rk4_pkg::*;
#(
   parameter int          FRAC_BITS = 28,
   parameter logic [43:0] STEP      = 44'd0
) (
   input  logic        clock,
   input  logic        en,
   input  vec_type     p_i,
   input  acc_vec_type s_i,
   output vec_type     n_o,
   output logic        escaped_o
);

   localparam logic [95:0] THR = 96'd10000 << (2 * FRAC_BITS);

   vec_type     m6, p3, n_in, n_ff, n3, n_out_ff, unused_q;
   logic [87:0] unused_prod [3];
   logic [87:0] sq [3];
   logic [95:0] sum;
   logic        esc_ff;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_six (.clock, .en, .a_i(s_i[i]), .b_i(STEP),
         .q_o(m6[i]), .prod_o(unused_prod[i]));
      rk4_fmul #(.FRAC_BITS(FRAC_BITS)) u_sq (.clock, .en, .a_i(ext44(n_ff[i])),
         .b_i(ext44(n_ff[i])), .q_o(unused_q[i]), .prod_o(sq[i]));
   end

   rk4_delay #(.WIDTH(3*PT_W), .DEPTH(3)) u_p (.clock, .en, .d_i(p_i), .q_o(p3));
   rk4_delay #(.WIDTH(3*PT_W), .DEPTH(3)) u_n (.clock, .en, .d_i(n_ff), .q_o(n3));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = sat40(ext46(p3[i]) + ext46(m6[i]));
      end
      sum = {8'd0, sq[0]} + {8'd0, sq[1]} + {8'd0, sq[2]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff     <= n_in;
         n_out_ff <= n3;
         esc_ff   <= (sum > THR);
      end
   end

   assign n_o       = n_out_ff;
   assign escaped_o = esc_ff;

endmodule

FILE: hdl/chaotic_ode_rk4_step.sv
// ----------------------------------------------------------------------------
// chaotic_ode_rk4_step
// Pipeline: four slope stages, then the update and escape test.
// Throughput: one word per cycle; the whole pipeline holds while a result
// waits on rsp_tready. Synchronous reset clears the valid bits and loads the
// default coefficients a = 0.2, b = 0.01, c = -0.4.
// ----------------------------------------------------------------------------
module chaotic_ode_rk4_step
   import rk4_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,   // point_x, point_y, point_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // next_x, next_y, next_z
   output logic [0:0]   rsp_tuser,   // escaped
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int          LATENCY    = 40;
   localparam logic [63:0] ONE_FX     = 64'd1 << FRAC_BITS;
   localparam logic [63:0] STEP_FULL  = (ONE_FX + 64'd30) / 64'd60;
   localparam logic [63:0] STEP_HALF  = (ONE_FX + 64'd60) / 64'd120;
   localparam logic [63:0] STEP_SIXTH = (ONE_FX + 64'd180) / 64'd360;

   logic [31:0]        coef_a_ff, coef_b_ff, coef_c_ff;
   logic [LATENCY-1:0] valid_ff;
   logic               en;
   vec_type            p_in, p1, p2, p3, p4, t1, t2, t3, t4, n;
   acc_vec_type        s1, s2, s3, s4;
   logic               escaped;

   assign en         = !valid_ff[LATENCY-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= COEF_A_RESET;
         coef_b_ff <= COEF_B_RESET;
         coef_c_ff <= COEF_C_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_A: begin
               coef_a_ff <= csr_wdata;
            end
            CSR_COEF_B: begin
               coef_b_ff <= csr_wdata;
            end
            CSR_COEF_C: begin
               coef_c_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_tvalid};
      end
   end

   assign p_in = req_tdata;

   rk4_kstage #(.FRAC_BITS(FRAC_BITS), .STEP(STEP_HALF[43:0]), .WEIGHT_TWO(1'b0)) u_k1 (
      .clock, .en, .coef_a_i(coef_a_ff), .coef_b_i(coef_b_ff), .coef_c_i(coef_c_ff),
      .p_i(p_in), .t_i(p_in), .s_i('0), .p_o(p1), .t_o(t1), .s_o(s1));
   rk4_kstage #(.FRAC_BITS(FRAC_BITS), .STEP(STEP_HALF[43:0]), .WEIGHT_TWO(1'b1)) u_k2 (
      .clock, .en, .coef_a_i(coef_a_ff), .coef_b_i(coef_b_ff), .coef_c_i(coef_c_ff),
      .p_i(p1), .t_i(t1), .s_i(s1), .p_o(p2), .t_o(t2), .s_o(s2));
   rk4_kstage #(.FRAC_BITS(FRAC_BITS), .STEP(STEP_FULL[43:0]), .WEIGHT_TWO(1'b1)) u_k3 (
      .clock, .en, .coef_a_i(coef_a_ff), .coef_b_i(coef_b_ff), .coef_c_i(coef_c_ff),
      .p_i(p2), .t_i(t2), .s_i(s2), .p_o(p3), .t_o(t3), .s_o(s3));
   rk4_kstage #(.FRAC_BITS(FRAC_BITS), .STEP(STEP_FULL[43:0]), .WEIGHT_TWO(1'b0)) u_k4 (
      .clock, .en, .coef_a_i(coef_a_ff), .coef_b_i(coef_b_ff), .coef_c_i(coef_c_ff),
      .p_i(p3), .t_i(t3), .s_i(s3), .p_o(p4), .t_o(t4), .s_o(s4));

   rk4_update #(.FRAC_BITS(FRAC_BITS), .STEP(STEP_SIXTH[43:0])) u_upd (
      .clock, .en, .p_i(p4), .s_i(s4), .n_o(n), .escaped_o(escaped));

   assign rsp_tdata = n;
   assign rsp_tuser = escaped;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while a result is stalled");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(valid_ff))
      else $error("pipeline moved during a stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
